>>> src/ssfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssfm_pkg;

    // input operation codes
    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_APPEND = 2'd1,
        OP_FEED   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    // width of the result position field
    localparam int OUT_POS_W = 32;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic       append;       // needle byte transfer
        logic       feed;         // haystack byte that updates the partial matches
        logic       clear_hay;    // clear the partial matches
        logic       clear_needle; // drop the needle
        logic [7:0] data;         // needle or haystack byte
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/substring_search_first_match.sv
// First-match substring search over a streamed byte haystack.
// Input channel (in_valid/in_ready, op, data_byte): op 0 starts a new search,
// op 1 appends a needle byte, op 2 feeds a haystack byte, op 3 ends the
// haystack. Only op 3 gives a result, on the output channel (out_valid/
// out_ready, found, match_position, needle_overflow).
// Throughput: one item per cycle while no op 3 waits on a held result. Every
// needle position is compared at once by a row of cells, one cell per needle
// byte. A result appears in the output register the cycle after its op 3
// transfer.
// Receiver stall: while a result waits, ops 0, 1 and 2 are still taken; an
// op 3 waits until the held result transfers (or transfers in the same cycle).
// Reset: the needle is empty, overflow clear, haystack state cleared, no
// result pending. Needle bytes beyond MAX_NEEDLE are dropped and flag
// overflow. Positions saturate at the largest POSITION_WIDTH value and are
// reported clamped to 32 bits.
`timescale 1ns / 1ps
`default_nettype none

module substring_search_first_match
    import ssfm_pkg::*;
#(
    parameter int MAX_NEEDLE     = 64,
    parameter int POSITION_WIDTH = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           op,
    input  wire logic [7:0]           data_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      found,
    output logic [OUT_POS_W-1:0]      match_position,
    output logic                      needle_overflow
);

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int PW    = POSITION_WIDTH;

    op_t                  op_in;
    logic                 in_xfer;
    logic                 out_xfer;
    cell_ctrl_t           ctrl;
    logic                 any_hit;
    logic                 needle_full;
    logic                 needle_empty;
    logic                 feed_active;

    logic [LEN_W-1:0]     needle_cnt_reg;
    logic [LEN_W-1:0]     needle_cnt_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic [PW-1:0]        bytes_seen_reg;
    logic [PW-1:0]        bytes_seen_next;
    logic                 match_seen_reg;
    logic                 match_seen_next;
    logic [PW-1:0]        first_start_reg;
    logic [PW-1:0]        first_start_next;
    logic [PW-1:0]        len_m1;
    logic [PW-1:0]        start_calc;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 found_reg;
    logic [OUT_POS_W-1:0] pos_reg;
    logic                 ovf_reg;
    logic [OUT_POS_W-1:0] pos_clamped;

    assign op_in    = op_t'(op);
    assign out_xfer = out_valid_reg & out_ready;
    // only an end of haystack needs room in the output register
    assign in_ready = (op_in != OP_END) | ~out_valid_reg | out_ready;
    assign in_xfer  = in_valid & in_ready;

    assign needle_full  = (needle_cnt_reg == LEN_W'(MAX_NEEDLE));
    assign needle_empty = (needle_cnt_reg == '0);
    assign feed_active  = ~needle_empty & ~overflow_reg;

    // cell control decode
    always_comb
    begin
        ctrl = '0;
        ctrl.data = data_byte;
        if (in_xfer)
        begin
            unique case (op_in)
                OP_NEW:
                begin
                    ctrl.clear_needle = 1'b1;
                    ctrl.clear_hay    = 1'b1;
                end
                OP_APPEND:
                begin
                    ctrl.append    = 1'b1;
                    ctrl.clear_hay = 1'b1;
                end
                OP_FEED:
                begin
                    ctrl.feed = ~overflow_reg;
                end
                OP_END:
                begin
                    ctrl.clear_hay = 1'b1;
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    ssfm_chain #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .any_hit (any_hit)
    );

    // start of a match that ends at the current byte
    assign len_m1     = {{(PW-LEN_W){1'b0}}, needle_cnt_reg} - PW'(1);
    assign start_calc = (bytes_seen_reg >= len_m1) ? (bytes_seen_reg - len_m1) : '0;

    // needle length, overflow and haystack tracking
    always_comb
    begin
        needle_cnt_next  = needle_cnt_reg;
        overflow_next    = overflow_reg;
        bytes_seen_next  = bytes_seen_reg;
        match_seen_next  = match_seen_reg;
        first_start_next = first_start_reg;
        if (in_xfer)
        begin
            unique case (op_in)
                OP_NEW:
                begin
                    needle_cnt_next  = '0;
                    overflow_next    = 1'b0;
                    bytes_seen_next  = '0;
                    match_seen_next  = 1'b0;
                    first_start_next = '0;
                end
                OP_APPEND:
                begin
                    if (needle_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        needle_cnt_next = needle_cnt_reg + LEN_W'(1);
                    end
                    bytes_seen_next  = '0;
                    match_seen_next  = 1'b0;
                    first_start_next = '0;
                end
                OP_FEED:
                begin
                    if (bytes_seen_reg != {PW{1'b1}})
                    begin
                        bytes_seen_next = bytes_seen_reg + PW'(1);
                    end
                    if (feed_active && !match_seen_reg && any_hit)
                    begin
                        match_seen_next  = 1'b1;
                        first_start_next = start_calc;
                    end
                end
                OP_END:
                begin
                    bytes_seen_next  = '0;
                    match_seen_next  = 1'b0;
                    first_start_next = '0;
                end
                default:
                begin
                    needle_cnt_next = needle_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_cnt_reg  <= '0;
            overflow_reg    <= 1'b0;
            bytes_seen_reg  <= '0;
            match_seen_reg  <= 1'b0;
            first_start_reg <= '0;
        end
        else
        begin
            needle_cnt_reg  <= needle_cnt_next;
            overflow_reg    <= overflow_next;
            bytes_seen_reg  <= bytes_seen_next;
            match_seen_reg  <= match_seen_next;
            first_start_reg <= first_start_next;
        end
    end

    // clamp the stored start to the result field
    if (PW > OUT_POS_W)
    begin : g_clamp
        assign pos_clamped = (|first_start_reg[PW-1:OUT_POS_W]) ?
                             {OUT_POS_W{1'b1}} : first_start_reg[OUT_POS_W-1:0];
    end
    else if (PW == OUT_POS_W)
    begin : g_same
        assign pos_clamped = first_start_reg;
    end
    else
    begin : g_widen
        assign pos_clamped = {{(OUT_POS_W-PW){1'b0}}, first_start_reg};
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_xfer;
        if (in_xfer && (op_in == OP_END))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on an end of haystack transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer && (op_in == OP_END))
        begin
            found_reg <= ~overflow_reg & (needle_empty | match_seen_reg);
            pos_reg   <= (~overflow_reg & ~needle_empty & match_seen_reg) ?
                         pos_clamped : '0;
            ovf_reg   <= overflow_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign match_position  = pos_reg;
    assign needle_overflow = ovf_reg;

    // overflow only happens with a full needle store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> needle_full)
        else $error("overflow set with needle store not full");

    // a recorded match needs a usable needle
    a_match_needle: assert property (@(posedge clk) disable iff (!rst_n)
        match_seen_reg |-> (!needle_empty && !overflow_reg))
        else $error("match recorded without a usable needle");

    // an end of haystack transfer always leaves a pending result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (op_in == OP_END)) |=> out_valid_reg)
        else $error("end of haystack gave no result");

    // a found result never carries overflow
    a_found_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && ovf_reg))
        else $error("result both found and overflowed");

endmodule

`default_nettype wire

>>> src/ssfm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ssfm_cell
    import ssfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       prev_active,
    input  wire logic       prev_match,
    input  wire logic       next_active,
    output logic            active,
    output logic            match,
    output logic            hit
);

    logic       active_reg;
    logic       active_next;
    logic       match_reg;
    logic       match_next;
    logic [7:0] byte_reg;
    logic       cmp;

    // this cell extends the previous partial match by one byte
    assign cmp = prev_match & active_reg & (byte_reg == ctrl.data);

    // needle occupancy: the first inactive cell takes the next needle byte
    always_comb
    begin
        active_next = active_reg;
        if (ctrl.clear_needle)
        begin
            active_next = 1'b0;
        end
        else if (ctrl.append && prev_active)
        begin
            active_next = 1'b1;
        end
    end

    // partial match bit
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.clear_hay)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.feed)
        begin
            match_next = cmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            match_reg  <= match_next;
        end
    end

    // needle byte store, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.append && prev_active && !active_reg && !ctrl.clear_needle)
        begin
            byte_reg <= ctrl.data;
        end
    end

    assign active = active_reg;
    assign match  = match_reg;
    // full match completes when this is the last needle cell
    assign hit    = cmp & ~next_active;

endmodule

`default_nettype wire

>>> src/ssfm_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module ssfm_chain
    import ssfm_pkg::*;
#(
    parameter int MAX_NEEDLE = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    output logic            any_hit
);

    logic [MAX_NEEDLE-1:0] active_w;
    logic [MAX_NEEDLE-1:0] match_w;
    logic [MAX_NEEDLE-1:0] hit_w;

    // row of cells, each linked to its neighbors
    for (genvar j = 0; j < MAX_NEEDLE; j++)
    begin : g_cell
        logic prev_active;
        logic prev_match;
        logic next_active;

        if (j == 0)
        begin : g_first
            assign prev_active = 1'b1;
            assign prev_match  = 1'b1;
        end
        else
        begin : g_link
            assign prev_active = active_w[j-1];
            assign prev_match  = match_w[j-1];
        end

        if (j == MAX_NEEDLE - 1)
        begin : g_last
            assign next_active = 1'b0;
        end
        else
        begin : g_next
            assign next_active = active_w[j+1];
        end

        ssfm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .prev_active (prev_active),
            .prev_match  (prev_match),
            .next_active (next_active),
            .active      (active_w[j]),
            .match       (match_w[j]),
            .hit         (hit_w[j])
        );
    end

    // only one cell is the last needle cell, so this is a plain or
    assign any_hit = |hit_w;

endmodule

`default_nettype wire

>>> bench/substring_search_first_match_tb.sv
`timescale 1ns / 1ps

module substring_search_first_match_tb
    import ssfm_pkg::*;
();

    localparam int NEEDLE_DEPTH = 64;
    localparam int POS_W        = 32;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] position;
        logic                 overflow;
    } match_t;

    // shift-and search predictor plus queue of pending search results
    class first_match_scoreboard;
        logic [7:0]              needle [NEEDLE_DEPTH];
        int                      needle_count;
        bit                      overflow;
        logic [NEEDLE_DEPTH-1:0] partial;
        logic [POS_W-1:0]        bytes_seen;
        bit                      match_seen;
        logic [POS_W-1:0]        first_start;
        match_t                  expected_matches [$];
        int                      failures;

        function new();
            foreach (needle[i])
                needle[i] = 8'h00;
            needle_count = 0;
            overflow     = 0;
            failures     = 0;
            clear_haystack();
        endfunction

        function void clear_haystack();
            partial     = '0;
            bytes_seen  = '0;
            match_seen  = 0;
            first_start = '0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // one haystack byte through the partial-match vector
        function void shift_in_haystack(logic [7:0] b);
            logic [NEEDLE_DEPTH-1:0] next_bits;
            logic [POS_W-1:0]        pos;
            int                      last;
            pos = bytes_seen;
            if (bytes_seen != '1)
                bytes_seen++;
            if (needle_count == 0 || overflow)
                return;
            next_bits = {partial[NEEDLE_DEPTH-2:0], 1'b1};
            for (int j = 0; j < NEEDLE_DEPTH; j++)
                if (j >= needle_count || needle[j] != b)
                    next_bits[j] = 1'b0;
            partial = next_bits;
            last = needle_count - 1;
            // only the first complete match counts
            if (!match_seen && partial[last])
            begin
                match_seen  = 1;
                first_start = (pos >= POS_W'(last)) ? pos - POS_W'(last) : '0;
            end
        endfunction

        // accepted input transfer
        function void note_transfer(op_t code, logic [7:0] b);
            match_t r;
            case (code)
                OP_NEW:
                begin
                    needle_count = 0;
                    overflow     = 0;
                    clear_haystack();
                end
                OP_APPEND:
                begin
                    if (needle_count < NEEDLE_DEPTH)
                    begin
                        needle[needle_count] = b;
                        needle_count++;
                    end
                    else
                        overflow = 1;
                    clear_haystack();
                end
                OP_FEED:
                    shift_in_haystack(b);
                default:
                begin
                    r.found    = !overflow && (needle_count == 0 || match_seen);
                    r.position = (!overflow && needle_count != 0 && match_seen) ?
                                 first_start : '0;
                    r.overflow = overflow;
                    expected_matches.push_back(r);
                    clear_haystack();
                end
            endcase
        endfunction

        // accepted output transfer
        function void check_result(logic f, logic [OUT_POS_W-1:0] p, logic o);
            match_t want;
            if (expected_matches.size() == 0)
            begin
                flag($sformatf("unexpected result: found=%0b position=%0d overflow=%0b",
                               f, p, o));
                return;
            end
            want = expected_matches.pop_front();
            if (f !== want.found || p !== want.position || o !== want.overflow)
                flag($sformatf({"mismatch: expected found=%0b position=%0d overflow=%0b,",
                                " got found=%0b position=%0d overflow=%0b"},
                               want.found, want.position, want.overflow, f, p, o));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op;
    logic [7:0]           data_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 found;
    logic [OUT_POS_W-1:0] match_position;
    logic                 needle_overflow;

    first_match_scoreboard sb = new();

    int  send_idle_pct;
    int  ready_stall_pct;
    int  items_sent;
    bit  hold_request;
    bit  run_started;

    substring_search_first_match i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .match_position  (match_position),
        .needle_overflow (needle_overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(op_t code, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        op        = code;
        data_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_transfer(code, b);
        items_sent++;
        @(negedge clk);
    endtask

    // sender stops until every pending result has been taken
    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.expected_matches.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte(bit wide, logic [7:0] letters [3]);
        return wide ? 8'($urandom_range(255)) : letters[$urandom_range(2)];
    endfunction

    // one search: needle load, haystack that may hold a planted needle, end of haystack; or a burst of random ops
    task automatic run_search();
        int         kind;
        int         nlen;
        int         hlen;
        int         start;
        int         mid_append;
        bit         wide;
        logic [7:0] letters [3];
        logic [7:0] needle_bytes [$];
        logic [7:0] hay [$];
        kind = $urandom_range(99);
        // noise: random ops and bytes
        if (kind < 8)
        begin
            repeat ($urandom_range(3, 12))
                send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        foreach (letters[i])
            letters[i] = 8'($urandom_range(255));
        wide = ($urandom_range(9) == 0);
        kind = $urandom_range(99);
        if (kind < 5)
            nlen = 0;
        else if (kind < 75)
            nlen = $urandom_range(1, 4);
        else if (kind < 88)
            nlen = $urandom_range(5, 12);
        else if (kind < 94)
            nlen = NEEDLE_DEPTH;
        else
            nlen = $urandom_range(NEEDLE_DEPTH + 1, NEEDLE_DEPTH + 3);
        if ($urandom_range(9) != 0)
            send_item(OP_NEW, 8'($urandom_range(255)));
        for (int i = 0; i < nlen; i++)
        begin
            needle_bytes.push_back(pick_byte(wide, letters));
            send_item(OP_APPEND, needle_bytes[i]);
        end
        if (nlen >= NEEDLE_DEPTH - 4)
            hlen = $urandom_range(NEEDLE_DEPTH - 4, NEEDLE_DEPTH + 16);
        else
            hlen = $urandom_range(0, 24);
        for (int i = 0; i < hlen; i++)
            hay.push_back(pick_byte(wide, letters));
        // plant the needle somewhere in the haystack
        if (nlen > 0 && nlen <= hlen && $urandom_range(99) < 65)
        begin
            start = $urandom_range(0, hlen - nlen);
            for (int k = 0; k < nlen; k++)
                hay[start + k] = needle_bytes[k];
        end
        // needle byte in the middle of the haystack now and then
        mid_append = ($urandom_range(24) == 0) ? $urandom_range(0, hlen) : -1;
        for (int i = 0; i < hlen; i++)
        begin
            if (i == mid_append)
                send_item(OP_APPEND, pick_byte(wide, letters));
            send_item(OP_FEED, hay[i]);
        end
        send_item(OP_END, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0)
            send_item(OP_END, 8'($urandom_range(255)));
    endtask

    // receiver ready with random stalls and one long hold-off on request
    initial
    begin
        wait (run_started);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ready = ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // output transfers go to the scoreboard
    initial
    begin
        wait (run_started);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(found, match_position, needle_overflow);
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // reset, directed items, then random phases
    initial
    begin
        int phase_start;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = OP_NEW;
        data_byte       = 8'h00;
        out_ready       = 1'b0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        items_sent      = 0;
        hold_request    = 0;
        run_started     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n       = 1'b1;
        run_started = 1;

        // empty needle over an empty and a non-empty haystack
        send_item(OP_END, 8'h00);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_END, 8'hFF);
        // haystack shorter than the needle
        send_item(OP_NEW, 8'h00);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_END, 8'h00);
        // first match kept over a later one
        send_item(OP_FEED, 8'h11);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_END, 8'h00);
        // repeated end of haystack searches an empty haystack
        send_item(OP_END, 8'hFF);
        // needle byte mid-haystack restarts the search
        send_item(OP_FEED, 8'hFF);
        send_item(OP_APPEND, 8'h55);
        send_item(OP_FEED, 8'hFF);
        send_item(OP_FEED, 8'h00);
        send_item(OP_FEED, 8'h55);
        send_item(OP_END, 8'h00);
        // new search drops the needle
        send_item(OP_NEW, 8'hAA);
        send_item(OP_END, 8'h55);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1:       begin send_idle_pct = 46; ready_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  ready_stall_pct = 46; end
                default: begin send_idle_pct = 10; ready_stall_pct = 10; end
            endcase
            // long receiver hold-off while the sender keeps going
            if (phase == 2)
                hold_request = 1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_search();
            if (phase == 1)
                drain_results();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.expected_matches.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.expected_matches.size()));
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
